[rtl/bgi_pkg.sv]
// Shared types and constants for the bilinear grid interpolator.
package bgi_pkg;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic [5:0]         load_col;
        logic [5:0]         load_row;
        logic signed [31:0] load_sample;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } rsp_item_t;

    typedef struct packed {
        logic signed [31:0] x_origin;
        logic signed [31:0] y_origin;
        logic [31:0]        x_inv_step;
        logic [31:0]        y_inv_step;
        logic [6:0]         cols_used;
        logic [6:0]         rows_used;
        logic               fill_enable;
        logic signed [31:0] fill_value;
    } cfg_t;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FILLED = 2'd1;
    localparam logic [1:0] STATUS_ERROR  = 2'd2;

    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_X_ORIGIN    = 3'd0;
    localparam logic [2:0] REG_Y_ORIGIN    = 3'd1;
    localparam logic [2:0] REG_X_INV_STEP  = 3'd2;
    localparam logic [2:0] REG_Y_INV_STEP  = 3'd3;
    localparam logic [2:0] REG_COLS_USED   = 3'd4;
    localparam logic [2:0] REG_ROWS_USED   = 3'd5;
    localparam logic [2:0] REG_FILL_ENABLE = 3'd6;
    localparam logic [2:0] REG_FILL_VALUE  = 3'd7;

    // result queue covers every query that can be in flight in the pipeline
    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = 3;
    localparam int Q_CNT_W = 4;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

endpackage

[rtl/bilinear_grid_interpolator.sv]
// Top level of the bilinear grid interpolator.
// Takes one transaction per cycle, loads and queries alike, unless stalled.
// A load writes one grid sample and returns nothing; a query returns one
// result from a six-stage pipeline around four parity-banked grid memories
// that deliver all four cell corners in one read. An eight-entry result
// queue decouples the output: the input stalls only while eight query
// results are outstanding. Loads and queries are kept in order, so a query
// sees every load accepted before it. The user must write registers over
// APB only while no transaction is in flight; the block does not enforce it.
module bilinear_grid_interpolator import bgi_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_item_t          req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_item_t          rsp_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t      cfg;
    logic      acc, take, push, full;
    rsp_item_t push_item;

    assign req_stall = full;
    assign acc       = req_valid && !req_stall;
    assign take      = acc && (req_item.kind == KIND_QUERY);

    bgi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bgi_pipe #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .acc       (acc),
        .item      (req_item),
        .push      (push),
        .push_item (push_item)
    );

    bgi_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .push      (push),
        .push_item (push_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .full      (full)
    );

endmodule

[rtl/bgi_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bgi_regs.sv]
// APB configuration register file.
module bgi_regs import bgi_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;

    assign idx    = paddr[PADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin    <= '0;
            cfg_reg.y_origin    <= '0;
            cfg_reg.x_inv_step  <= 32'h0001_0000;
            cfg_reg.y_inv_step  <= 32'h0001_0000;
            cfg_reg.cols_used   <= 7'd64;
            cfg_reg.rows_used   <= 7'd64;
            cfg_reg.fill_enable <= 1'b0;
            cfg_reg.fill_value  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_X_ORIGIN:    cfg_reg.x_origin    <= pwdata;
                REG_Y_ORIGIN:    cfg_reg.y_origin    <= pwdata;
                REG_X_INV_STEP:  cfg_reg.x_inv_step  <= pwdata;
                REG_Y_INV_STEP:  cfg_reg.y_inv_step  <= pwdata;
                REG_COLS_USED:   cfg_reg.cols_used   <= pwdata[6:0];
                REG_ROWS_USED:   cfg_reg.rows_used   <= pwdata[6:0];
                REG_FILL_ENABLE: cfg_reg.fill_enable <= pwdata[0];
                REG_FILL_VALUE:  cfg_reg.fill_value  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_X_ORIGIN:    prdata = cfg_reg.x_origin;
            REG_Y_ORIGIN:    prdata = cfg_reg.y_origin;
            REG_X_INV_STEP:  prdata = cfg_reg.x_inv_step;
            REG_Y_INV_STEP:  prdata = cfg_reg.y_inv_step;
            REG_COLS_USED:   prdata = {25'd0, cfg_reg.cols_used};
            REG_ROWS_USED:   prdata = {25'd0, cfg_reg.rows_used};
            REG_FILL_ENABLE: prdata = {31'd0, cfg_reg.fill_enable};
            REG_FILL_VALUE:  prdata = cfg_reg.fill_value;
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[rtl/bgi_pipe.sv]
// Interpolation pipeline over four parity-banked grid memories.
module bgi_pipe import bgi_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      acc,
    input  req_item_t item,
    output logic      push,
    output rsp_item_t push_item
);

    localparam int COLW       = $clog2(MAX_COLS);
    localparam int ROWW       = $clog2(MAX_ROWS);
    localparam int COLS_H     = (MAX_COLS + 1) / 2;
    localparam int ROWS_H     = (MAX_ROWS + 1) / 2;
    localparam int BANK_DEPTH = COLS_H * ROWS_H;
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // stage 1: offset from origin
    logic               r1_vld_reg, r1_kind_reg;
    logic signed [32:0] r1_dx_reg, r1_dy_reg;
    logic [5:0]         r1_lcol_reg, r1_lrow_reg;
    logic [31:0]        r1_lsmp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg <= 1'b0;
        end
        else
        begin
            r1_vld_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        r1_kind_reg <= item.kind;
        r1_dx_reg   <= {item.x_coord[31], item.x_coord} - {cfg.x_origin[31], cfg.x_origin};
        r1_dy_reg   <= {item.y_coord[31], item.y_coord} - {cfg.y_origin[31], cfg.y_origin};
        r1_lcol_reg <= item.load_col;
        r1_lrow_reg <= item.load_row;
        r1_lsmp_reg <= item.load_sample;
    end

    // stage 2: scale to grid units, Q32.32
    logic        r2_vld_reg, r2_kind_reg, r2_negx_reg, r2_negy_reg;
    logic [63:0] r2_px_reg, r2_py_reg;
    logic [5:0]  r2_lcol_reg, r2_lrow_reg;
    logic [31:0] r2_lsmp_reg;
    logic [32:0] magx, magy;
    logic [63:0] px, py;

    always_comb
    begin
        magx = r1_dx_reg[32] ? 33'(-r1_dx_reg) : 33'(r1_dx_reg);
        magy = r1_dy_reg[32] ? 33'(-r1_dy_reg) : 33'(r1_dy_reg);
        // magnitude never exceeds 2^32, so bit 32 alone adds inv_step << 32
        px = 64'(magx[31:0]) * 64'(cfg.x_inv_step)
           + (magx[32] ? {cfg.x_inv_step, 32'd0} : 64'd0);
        py = 64'(magy[31:0]) * 64'(cfg.y_inv_step)
           + (magy[32] ? {cfg.y_inv_step, 32'd0} : 64'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_vld_reg <= 1'b0;
        end
        else
        begin
            r2_vld_reg <= r1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r2_kind_reg <= r1_kind_reg;
        r2_negx_reg <= r1_dx_reg[32];
        r2_negy_reg <= r1_dy_reg[32];
        r2_px_reg   <= px;
        r2_py_reg   <= py;
        r2_lcol_reg <= r1_lcol_reg;
        r2_lrow_reg <= r1_lrow_reg;
        r2_lsmp_reg <= r1_lsmp_reg;
    end

    // stage 3: range check, corner addresses, memory access
    logic [31:0]     ncols, nrows, ix, iy, ixp32, iyp32;
    logic            oob;
    logic [COLW-1:0] ixn, ixpn, lcoln;
    logic [ROWW-1:0] iyn, iypn, lrown;
    logic [COLW-1:0] colsel [2];
    logic [ROWW-1:0] rowsel [2];
    logic [BAW-1:0]  rd_addr [4];
    logic [BAW-1:0]  wr_addr;
    logic [3:0]      wr_en;
    logic [31:0]     rd_data [4];
    logic            load_ok;
    logic            q_vld;

    always_comb
    begin
        ncols = (32'(cfg.cols_used) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(cfg.cols_used);
        nrows = (32'(cfg.rows_used) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(cfg.rows_used);
        ix    = r2_px_reg[63:32];
        iy    = r2_py_reg[63:32];
        // below origin is out of range unless it lands exactly on zero
        oob   = (r2_negx_reg && (r2_px_reg != 64'd0))
             || (r2_negy_reg && (r2_py_reg != 64'd0))
             || (ix >= ncols) || (iy >= nrows);
        ixp32 = (ix + 32'd1 >= ncols) ? ncols - 32'd1 : ix + 32'd1;
        iyp32 = (iy + 32'd1 >= nrows) ? nrows - 32'd1 : iy + 32'd1;
        ixn   = ix[COLW-1:0];
        ixpn  = ixp32[COLW-1:0];
        iyn   = iy[ROWW-1:0];
        iypn  = iyp32[ROWW-1:0];
        // each parity bank serves whichever of the two columns/rows has its parity
        for (int p = 0; p < 2; p++)
        begin
            colsel[p] = (ixn[0] == p[0]) ? ixn : ixpn;
            rowsel[p] = (iyn[0] == p[0]) ? iyn : iypn;
        end
        for (int b = 0; b < 4; b++)
        begin
            rd_addr[b] = BAW'(32'(rowsel[b[1]] >> 1) * COLS_H + 32'(colsel[b[0]] >> 1));
        end
        lcoln   = COLW'(r2_lcol_reg);
        lrown   = ROWW'(r2_lrow_reg);
        load_ok = (32'(r2_lcol_reg) < 32'(MAX_COLS)) && (32'(r2_lrow_reg) < 32'(MAX_ROWS));
        wr_addr = BAW'(32'(lrown >> 1) * COLS_H + 32'(lcoln >> 1));
        for (int b = 0; b < 4; b++)
        begin
            wr_en[b] = r2_vld_reg && (r2_kind_reg == KIND_LOAD) && load_ok
                    && ({lrown[0], lcoln[0]} == b[1:0]);
        end
        q_vld = r2_vld_reg && (r2_kind_reg == KIND_QUERY);
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        bgi_ram #(
            .WIDTH (32),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en[g]),
            .waddr (wr_addr),
            .wdata (r2_lsmp_reg),
            .raddr (rd_addr[g]),
            .rdata (rd_data[g])
        );
    end

    logic        r3_vld_reg;
    logic [1:0]  r3_status_reg;
    logic [15:0] r3_t_reg, r3_u_reg;
    logic        r3_cx0_reg, r3_cx1_reg, r3_ry0_reg, r3_ry1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r3_vld_reg <= 1'b0;
        end
        else
        begin
            r3_vld_reg <= q_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        r3_status_reg <= !oob ? STATUS_OK : (cfg.fill_enable ? STATUS_FILLED : STATUS_ERROR);
        r3_t_reg      <= r2_px_reg[31:16];
        r3_u_reg      <= r2_py_reg[31:16];
        r3_cx0_reg    <= ixn[0];
        r3_cx1_reg    <= ixpn[0];
        r3_ry0_reg    <= iyn[0];
        r3_ry1_reg    <= iypn[0];
    end

    // stage 4: pick corner samples, form weights
    // corner order: (ix,iy) (ixp,iy) (ixp,iyp) (ix,iyp)
    logic               r4_vld_reg;
    logic [1:0]         r4_status_reg;
    logic signed [31:0] r4_smp_reg [4];
    logic [32:0]        r4_w_reg [4];
    logic [16:0]        ut, uu, tt, uv;
    logic [33:0]        wp [4];

    always_comb
    begin
        tt    = {1'b0, r3_t_reg};
        uv    = {1'b0, r3_u_reg};
        ut    = ONE_Q16 - tt;
        uu    = ONE_Q16 - uv;
        wp[0] = 34'(ut) * 34'(uu);
        wp[1] = 34'(tt) * 34'(uu);
        wp[2] = 34'(tt) * 34'(uv);
        wp[3] = 34'(ut) * 34'(uv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r4_vld_reg <= 1'b0;
        end
        else
        begin
            r4_vld_reg <= r3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r4_status_reg <= r3_status_reg;
        r4_smp_reg[0] <= rd_data[{r3_ry0_reg, r3_cx0_reg}];
        r4_smp_reg[1] <= rd_data[{r3_ry0_reg, r3_cx1_reg}];
        r4_smp_reg[2] <= rd_data[{r3_ry1_reg, r3_cx1_reg}];
        r4_smp_reg[3] <= rd_data[{r3_ry1_reg, r3_cx0_reg}];
        for (int k = 0; k < 4; k++)
        begin
            r4_w_reg[k] <= wp[k][32:0];
        end
    end

    // stage 5: weighted products
    logic               r5_vld_reg;
    logic [1:0]         r5_status_reg;
    logic signed [63:0] r5_prod_reg [4];
    logic signed [64:0] mp [4];
    logic signed [63:0] prod [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            mp[k]   = $signed({1'b0, r4_w_reg[k][31:0]}) * r4_smp_reg[k];
            // a weight of exactly 1.0 carries in bit 32
            prod[k] = mp[k][63:0] + (r4_w_reg[k][32] ? {r4_smp_reg[k], 32'd0} : 64'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r5_vld_reg <= 1'b0;
        end
        else
        begin
            r5_vld_reg <= r4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r5_status_reg <= r4_status_reg;
        for (int k = 0; k < 4; k++)
        begin
            r5_prod_reg[k] <= prod[k];
        end
    end

    // stage 6: sum, round to nearest (ties up), select result
    logic signed [63:0] sum;

    always_comb
    begin
        sum  = r5_prod_reg[0] + r5_prod_reg[1] + r5_prod_reg[2] + r5_prod_reg[3]
             + 64'sh8000_0000;
        push = r5_vld_reg;
        push_item.status = r5_status_reg;
        case (r5_status_reg)
            STATUS_OK:     push_item.value = sum[63:32];
            STATUS_FILLED: push_item.value = cfg.fill_value;
            default:       push_item.value = '0;
        endcase
    end

endmodule

[rtl/bgi_outq.sv]
// Result queue with credit count toward the input side.
module bgi_outq import bgi_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  logic      push,
    input  rsp_item_t push_item,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp_item,
    output logic      full
);

    rsp_item_t          q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] q_cnt_reg, q_cnt_next;
    logic [Q_CNT_W-1:0] credit_reg, credit_next;
    logic               pop;

    assign rsp_valid = (q_cnt_reg != '0);
    assign rsp_item  = q_reg[rd_ptr_reg];
    assign pop       = rsp_valid && !rsp_stall;
    assign full      = (credit_reg == Q_CNT_W'(Q_DEPTH));

    always_comb
    begin
        q_cnt_next  = q_cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        credit_next = credit_reg + Q_CNT_W'(take) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            q_cnt_reg  <= q_cnt_next;
            credit_reg <= credit_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
